// ===== design/tbtm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbtm_pkg
// Shared widths, codes, command types and the sine table of the tape byte
// tone modulator.
// ----------------------------------------------------------------------------
package tbtm_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int FRAME_BITS  = 13;
	localparam int DATA_BITS   = 8;
	localparam int POS_W       = $clog2(FRAME_BITS + 1);

	localparam int TONE_W  = 15;
	localparam int PER_W   = 8;
	localparam int RATE_W  = 18;
	localparam int GAIN_W  = 15;
	localparam int CNT_W   = 16;
	localparam int SMP_W   = 16;
	localparam int CFG_W   = 18;
	localparam int CFG_AW  = 3;

	// The divider covers both the phase-to-index scaling and periods*rate.
	localparam int DIV_W   = (RATE_W + TBL_AW > PER_W + RATE_W) ?
	                         RATE_W + TBL_AW : PER_W + RATE_W;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Taylor series denominators (2n)*(2n+1) for n = 1 to 8.
	localparam longint unsigned TAYLOR_DEN [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	typedef enum logic [CFG_AW-1:0] {
		REG_TONE_ONE   = 3'd0,
		REG_PER_ONE    = 3'd1,
		REG_TONE_ZERO  = 3'd2,
		REG_PER_ZERO   = 3'd3,
		REG_RATE       = 3'd4,
		REG_GAIN       = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                  pull;
		logic [FRAME_BITS-1:0] frame;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    valid;
		logic                    done;
		logic                    accepted;
	} res_t;

	typedef logic signed [SMP_W-1:0] sine_rom_t [TABLE_DEPTH];

	// sin(pi/2 * r / TABLE_DEPTH) in Q1.15 by a Taylor series in Q30.
	function automatic logic [SMP_W-2:0] quarter_sine(input longint unsigned r);
		longint unsigned x;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		begin
			x    = HALF_PI_Q30 * r / TABLE_DEPTH;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / TAYLOR_DEN[n-1];
				if ((n % 2) == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			v = ((longint'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) v = 64'd32767;
			return v[SMP_W-2:0];
		end
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t       t;
		longint unsigned n;
		longint unsigned d;
		begin
			d = TABLE_DEPTH;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				n = 4 * longint'(k);
				if (n <= d) t[k] = $signed({1'b0, quarter_sine(n)});
				else if (n <= 2 * d) t[k] = $signed({1'b0, quarter_sine(2 * d - n)});
				else if (n <= 3 * d) t[k] = -$signed({1'b0, quarter_sine(n - 2 * d)});
				else t[k] = -$signed({1'b0, quarter_sine(4 * d - n)});
			end
			return t;
		end
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ===== design/tbtm_if.sv =====
// ----------------------------------------------------------------------------
// tbtm_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface tbtm_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] byte_value;

	modport source (output valid, opcode, byte_value, input ready);
	modport sink   (input valid, opcode, byte_value, output ready);
endinterface

interface tbtm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               sample_valid;
	logic               frame_done;
	logic               load_accepted;

	modport source (output valid, sample_out, sample_valid, frame_done, load_accepted,
	                input ready);
	modport sink   (input valid, sample_out, sample_valid, frame_done, load_accepted,
	                output ready);
endinterface

// ===== design/tbtm_front.sv =====
// ----------------------------------------------------------------------------
// tbtm_front
// Accepts input beats, frames load bytes and queues commands for the back end.
// ----------------------------------------------------------------------------
module tbtm_front
	import tbtm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tbtm_in_if.sink    in_ch,
	output cmd_beat_t  cmd,
	input  logic       cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       new_cmd;
	logic       push;
	logic       pop;

	// Even number of ones gives a parity bit of one.
	always_comb begin
		new_cmd.pull  = in_ch.opcode;
		new_cmd.frame = {3'b111, ~^in_ch.byte_value, in_ch.byte_value, 1'b0};
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = cmd_pop && (count_q != 2'd0);
	assign cmd.valid   = (count_q != 2'd0);
	assign cmd.cmd     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/tbtm_div.sv =====
// ----------------------------------------------------------------------------
// tbtm_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbtm_div
	import tbtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [RATE_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quot,
	output logic [RATE_W-1:0] rem
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W-1:0]  quot_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] den_q;
	logic [RATE_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quot_q[DIV_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? RATE_W'(trial - {1'b0, den_q}) : trial[RATE_W-1:0];
			quot_q <= {quot_q[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== design/tbtm_back.sv =====
// ----------------------------------------------------------------------------
// tbtm_back
// Executes queued commands: bit timing, phase tracking, sine lookup and gain.
// ----------------------------------------------------------------------------
module tbtm_back
	import tbtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_beat_t         cmd,
	output logic              cmd_pop,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	tbtm_out_if.source        out_ch
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIV_GO = 7'b0000010,
		ST_DIV_WT = 7'b0000100,
		ST_ROM    = 7'b0001000,
		ST_MUL    = 7'b0010000,
		ST_STEP   = 7'b0100000,
		ST_SCAN   = 7'b1000000
	} state_t;

	typedef enum logic [6:0] {
		J_P1  = 7'b0000001,
		J_P0  = 7'b0000010,
		J_T1  = 7'b0000100,
		J_T0  = 7'b0001000,
		J_IDX = 7'b0010000,
		J_C1  = 7'b0100000,
		J_C0  = 7'b1000000
	} job_t;

	state_t state_q;
	job_t   job_q;
	logic   out_pend_q;

	logic [TONE_W-1:0] tone1_q, tone0_q;
	logic [PER_W-1:0]  per1_q, per0_q;
	logic [RATE_W-1:0] rate_q;
	logic [GAIN_W-1:0] gain_q;

	logic [FRAME_BITS-1:0] frame_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      from_q;
	logic [CNT_W-1:0]      left_q;
	logic                  busy_q;
	logic [RATE_W-1:0]     ph1_q, ph0_q;
	logic [RATE_W-1:0]     p1r_q, p0r_q, t1r_q, t0r_q;
	logic [TBL_AW-1:0]     idx_q;
	logic [CNT_W-1:0]      cnt1_q, cnt0_q;
	logic                  pull_q;
	logic signed [SMP_W-1:0] sine_q;
	logic [GAIN_W+SMP_W-2:0] prod_q;
	res_t                  pend_q;
	res_t                  out_q;
	logic                  out_valid_q;

	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [RATE_W-1:0] div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;
	logic [RATE_W-1:0] div_rem;

	logic [PER_W+RATE_W-1:0] c1_prod, c0_prod;
	logic [RATE_W-1:0]       ph_sel;
	logic                    cur_bit;
	logic                    quot_big;
	logic [CNT_W-1:0]        quot_sat;
	logic [RATE_W:0]         s1, s0;
	logic [RATE_W-1:0]       ph1_n, ph0_n;
	logic                    neg;
	logic [SMP_W-1:0]        neg_t;
	logic [SMP_W-2:0]        mag;
	logic [GAIN_W-1:0]       amp;
	logic [SMP_W-1:0]        amp_n;
	logic [CNT_W-1:0]        left_n;
	logic                    found;
	logic [POS_W-1:0]        pos_f;
	logic                    out_free;

	tbtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign cur_bit   = frame_q[pos_q];
	assign ph_sel    = cur_bit ? p1r_q : p0r_q;
	assign c1_prod   = per1_q * rate_q;
	assign c0_prod   = per0_q * rate_q;
	assign div_start = (state_q == ST_DIV_GO);

	always_comb begin
		div_divisor = rate_q;
		case (job_q)
			J_P1:    div_dividend = DIV_W'(ph1_q);
			J_P0:    div_dividend = DIV_W'(ph0_q);
			J_T1:    div_dividend = DIV_W'(tone1_q);
			J_T0:    div_dividend = DIV_W'(tone0_q);
			J_IDX:   div_dividend = DIV_W'({ph_sel, {TBL_AW{1'b0}}});
			J_C1: begin
				div_dividend = DIV_W'(c1_prod);
				div_divisor  = RATE_W'(tone1_q);
			end
			J_C0: begin
				div_dividend = DIV_W'(c0_prod);
				div_divisor  = RATE_W'(tone0_q);
			end
			default: div_dividend = '0;
		endcase
	end

	assign quot_big = |div_quot[DIV_W-1:CNT_W];
	assign quot_sat = quot_big ? {CNT_W{1'b1}} : div_quot[CNT_W-1:0];

	// Both phases advance by their tone, wrapped once at the rate.
	assign s1    = {1'b0, p1r_q} + {1'b0, t1r_q};
	assign s0    = {1'b0, p0r_q} + {1'b0, t0r_q};
	assign ph1_n = (s1 >= {1'b0, rate_q}) ? RATE_W'(s1 - {1'b0, rate_q}) : s1[RATE_W-1:0];
	assign ph0_n = (s0 >= {1'b0, rate_q}) ? RATE_W'(s0 - {1'b0, rate_q}) : s0[RATE_W-1:0];

	assign neg   = sine_q[SMP_W-1];
	assign neg_t = SMP_W'(-sine_q);
	assign mag   = neg ? neg_t[SMP_W-2:0] : sine_q[SMP_W-2:0];
	assign amp   = prod_q[GAIN_W+SMP_W-2:SMP_W-1];
	assign amp_n = SMP_W'(-{1'b0, amp});

	assign left_n = left_q - 1'b1;

	// Lowest frame bit at or after from_q whose tone yields samples.
	always_comb begin
		found = 1'b0;
		pos_f = '0;
		for (int p = FRAME_BITS - 1; p >= 0; p--) begin
			if ((POS_W'(p) >= from_q) && (frame_q[p] ? (cnt1_q != '0) : (cnt0_q != '0))) begin
				found = 1'b1;
				pos_f = POS_W'(p);
			end
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;
	assign cmd_pop  = (state_q == ST_IDLE) && !out_pend_q && cmd.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone1_q <= TONE_W'(2400);
			per1_q  <= PER_W'(1);
			tone0_q <= TONE_W'(1200);
			per0_q  <= PER_W'(1);
			rate_q  <= RATE_W'(44100);
			gain_q  <= GAIN_W'(32000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TONE_ONE:  tone1_q <= cfg_wdata[TONE_W-1:0];
				REG_PER_ONE:   per1_q  <= cfg_wdata[PER_W-1:0];
				REG_TONE_ZERO: tone0_q <= cfg_wdata[TONE_W-1:0];
				REG_PER_ZERO:  per0_q  <= cfg_wdata[PER_W-1:0];
				REG_RATE:      rate_q  <= cfg_wdata[RATE_W-1:0];
				REG_GAIN:      gain_q  <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_ROM:  sine_q <= SINE_ROM[idx_q];
			ST_MUL:  prod_q <= gain_q * mag;
			default: ;
		endcase
		// With a zero rate the lookup always uses the first table entry.
		if (cmd_pop && cmd.cmd.pull && busy_q && rate_q == '0)
			idx_q <= '0;
		if (state_q == ST_DIV_WT && div_done) begin
			case (job_q)
				J_P1:    p1r_q  <= div_rem;
				J_P0:    p0r_q  <= div_rem;
				J_T1:    t1r_q  <= div_rem;
				J_T0:    t0r_q  <= div_rem;
				J_IDX:   idx_q  <= (|div_quot[DIV_W-1:TBL_AW]) ? {TBL_AW{1'b1}} :
				                   div_quot[TBL_AW-1:0];
				J_C1:    cnt1_q <= (tone1_q == '0) ? '0 : quot_sat;
				J_C0:    cnt0_q <= (tone0_q == '0) ? '0 : quot_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= J_P1;
			out_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			pend_q      <= '0;
			frame_q     <= '0;
			pos_q       <= '0;
			from_q      <= '0;
			left_q      <= '0;
			busy_q      <= 1'b0;
			ph1_q       <= '0;
			ph0_q       <= '0;
			pull_q      <= 1'b0;
		end else begin
			if (out_pend_q && out_free) begin
				out_q       <= pend_q;
				out_valid_q <= 1'b1;
				out_pend_q  <= 1'b0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						pull_q <= cmd.cmd.pull;
						pend_q <= '{sample: '0, valid: 1'b0, done: 1'b0,
						            accepted: !cmd.cmd.pull && !busy_q};
						if (!cmd.cmd.pull) begin
							if (busy_q) begin
								out_pend_q <= 1'b1;
							end else begin
								frame_q         <= cmd.cmd.frame;
								from_q          <= '0;
								job_q           <= J_C1;
								state_q         <= ST_DIV_GO;
							end
						end else if (!busy_q) begin
							out_pend_q <= 1'b1;
						end else if (rate_q == '0) begin
							state_q <= ST_ROM;
						end else begin
							job_q   <= J_P1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WT;
				ST_DIV_WT: begin
					if (div_done) begin
						state_q <= ST_DIV_GO;
						case (job_q)
							J_P1: job_q <= J_P0;
							J_P0: job_q <= J_T1;
							J_T1: job_q <= J_T0;
							J_T0: job_q <= J_IDX;
							J_IDX: begin
								ph1_q   <= ph1_n;
								ph0_q   <= ph0_n;
								state_q <= ST_ROM;
							end
							J_C1: job_q <= J_C0;
							J_C0: state_q <= ST_SCAN;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ROM: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_STEP;
				ST_STEP: begin
					pend_q <= '{sample: (neg ? $signed(amp_n) : $signed({1'b0, amp})),
					            valid: 1'b1, done: 1'b0, accepted: 1'b0};
					left_q        <= left_n;
					if (left_n == '0) begin
						from_q  <= POS_W'(pos_q + 1'b1);
						job_q   <= J_C1;
						state_q <= ST_DIV_GO;
					end else begin
						out_pend_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (found) begin
						pos_q  <= pos_f;
						left_q <= frame_q[pos_f] ? cnt1_q : cnt0_q;
						busy_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
						if (pull_q) pend_q.done <= 1'b1;
					end
					out_pend_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.sample_out    = out_q.sample;
	assign out_ch.sample_valid  = out_q.valid;
	assign out_ch.frame_done    = out_q.done;
	assign out_ch.load_accepted = out_q.accepted;

endmodule

// ===== design/tape_byte_tone_modulator_core.sv =====
// ----------------------------------------------------------------------------
// tape_byte_tone_modulator_core
// Frames bytes for cassette tape and emits sine tone samples, one per pull while a frame is active.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     sink       opcode, byte_value
// out_ch    source     sample_out, sample_valid, frame_done, load_accepted
// cfg       write      cfg_we, cfg_index, cfg_wdata
//
// One shared serial divider sets the pace. A pull runs five divisions (none when
// the rate is zero), plus two more when a bit ends; a load runs two divisions,
// and a refused load or an idle pull runs none.
// Reset clears all control state; the sine table is a constant ROM.
// A two-beat command queue lets input beats arrive while a result is held.
// ----------------------------------------------------------------------------
module tape_byte_tone_modulator_core
	import tbtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tbtm_in_if.sink           in_ch,
	tbtm_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cmd_beat_t cmd;
	logic      cmd_pop;

	tbtm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	tbtm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.sample_valid && out_ch.load_accepted))
		else $error("result both a sample and a load acknowledge");
	a_done_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.frame_done) |-> out_ch.sample_valid)
		else $error("frame end without a sample");
	a_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.sample_valid) |-> (out_ch.sample_out == 16'sd0))
		else $error("nonzero sample without a sample beat");
`endif

endmodule
